[rtl/cat_pkg.sv]
`default_nettype none

package cat_pkg;

    // Remaining time kept in mixed radix, so no division is needed for the display.
    typedef struct packed {
        logic [6:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } hms_t;

    typedef logic [1:0] unit_t;
    typedef logic [0:0] cfg_index_t;

    localparam unit_t UNIT_HOURS   = 2'd0;
    localparam unit_t UNIT_MINUTES = 2'd1;
    localparam unit_t UNIT_SECONDS = 2'd2;
    localparam unit_t UNIT_UNUSED  = 2'd3;

    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_BUTTON = 1'b1;

    localparam cfg_index_t CFG_TICK_PERIOD  = 1'b0;
    localparam cfg_index_t CFG_REFRESH_SLOT = 1'b1;

    localparam logic [7:0] TICK_PERIOD_RESET  = 8'd61;
    localparam logic [7:0] REFRESH_SLOT_RESET = 8'd9;

    localparam logic [6:0] HOURS_MAX   = 7'd99;
    localparam logic [5:0] MINUTES_MAX = 6'd59;
    localparam logic [5:0] SECONDS_MAX = 6'd59;

    localparam hms_t TIME_ZERO = '{hours: 7'd0, minutes: 6'd0, seconds: 6'd0};
    localparam hms_t TIME_FULL = '{hours: HOURS_MAX, minutes: MINUTES_MAX, seconds: SECONDS_MAX};

endpackage

`default_nettype wire

[rtl/countdown_alarm_timer.sv]
`default_nettype none

// Countdown alarm timer with an hh:mm:ss display value. Every input transfer is either
// one prescaler tick (s_func low) or one button event (s_func high) that may carry
// several buttons at once; within an event the buttons act in the order up, mode,
// down, start. Start while running stops the countdown and clears both time and alarm.
// On a tick the prescale count advances and wraps to zero once it reaches tick_period;
// when it equals refresh_slot (unless running at zero) the display is flagged for a
// redraw and a running countdown loses one second, raising the alarm when it reaches
// zero. The time saturates at 00:00:00 and 99:59:59. Every input transfer yields
// exactly one result transfer. The block takes one item per clock: the whole state
// update is one pass of narrow mixed-radix logic from the state registers back into
// themselves, and the result is registered with the input transfer. The output
// register frees itself in the same cycle it is taken, so s_ready stays high as long
// as the consumer keeps up. Configuration (cfg_we, cfg_index, cfg_data) is a plain
// write port: index 0 is tick_period (reset 61), index 1 is refresh_slot (reset 9).
// There is no clearing pass after reset; the block is ready as soon as reset is released.
module countdown_alarm_timer (
    input  wire                 aclk,
    input  wire                 aresetn,

    input  wire                 cfg_we,
    input  cat_pkg::cfg_index_t cfg_index,
    input  wire  [7:0]          cfg_data,

    input  wire                 s_valid,
    output logic                s_ready,
    input  wire                 s_func,
    input  wire                 s_btn_up,
    input  wire                 s_btn_mode,
    input  wire                 s_btn_down,
    input  wire                 s_btn_start,

    output logic                m_valid,
    input  wire                 m_ready,
    output logic [6:0]          m_hours,
    output logic [5:0]          m_minutes,
    output logic [5:0]          m_seconds,
    output logic                m_alarm_out,
    output logic                m_running,
    output logic [1:0]          m_edit_unit,
    output logic                m_refresh,
    output logic                m_alarm_message
);

    // Adds one edit unit, saturating at the top of the range.
    function automatic cat_pkg::hms_t add_unit(input cat_pkg::hms_t t,
                                               input cat_pkg::unit_t u);
        cat_pkg::hms_t r;
        r = t;
        case (u)
            cat_pkg::UNIT_HOURS: begin
                if (t.hours >= cat_pkg::HOURS_MAX) begin
                    r = cat_pkg::TIME_FULL;
                end else begin
                    r.hours = t.hours + 7'd1;
                end
            end
            cat_pkg::UNIT_MINUTES: begin
                if (t.hours >= cat_pkg::HOURS_MAX && t.minutes >= cat_pkg::MINUTES_MAX) begin
                    r = cat_pkg::TIME_FULL;
                end else if (t.minutes >= cat_pkg::MINUTES_MAX) begin
                    r.minutes = 6'd0;
                    r.hours   = t.hours + 7'd1;
                end else begin
                    r.minutes = t.minutes + 6'd1;
                end
            end
            cat_pkg::UNIT_SECONDS: begin
                if (t == cat_pkg::TIME_FULL) begin
                    r = cat_pkg::TIME_FULL;
                end else if (t.seconds < cat_pkg::SECONDS_MAX) begin
                    r.seconds = t.seconds + 6'd1;
                end else if (t.minutes < cat_pkg::MINUTES_MAX) begin
                    r.seconds = 6'd0;
                    r.minutes = t.minutes + 6'd1;
                end else begin
                    r.seconds = 6'd0;
                    r.minutes = 6'd0;
                    r.hours   = t.hours + 7'd1;
                end
            end
            default: begin
                r = t;
            end
        endcase
        return r;
    endfunction

    // Takes one second off, with borrow; zero stays zero.
    function automatic cat_pkg::hms_t dec_one(input cat_pkg::hms_t t);
        cat_pkg::hms_t r;
        r = t;
        if (t.seconds != 6'd0) begin
            r.seconds = t.seconds - 6'd1;
        end else if (t.minutes != 6'd0) begin
            r.seconds = cat_pkg::SECONDS_MAX;
            r.minutes = t.minutes - 6'd1;
        end else if (t.hours != 7'd0) begin
            r.seconds = cat_pkg::SECONDS_MAX;
            r.minutes = cat_pkg::MINUTES_MAX;
            r.hours   = t.hours - 7'd1;
        end else begin
            r = cat_pkg::TIME_ZERO;
        end
        return r;
    endfunction

    // Subtracts one edit unit, saturating at zero.
    function automatic cat_pkg::hms_t sub_unit(input cat_pkg::hms_t t,
                                               input cat_pkg::unit_t u);
        cat_pkg::hms_t r;
        r = t;
        case (u)
            cat_pkg::UNIT_HOURS: begin
                if (t.hours != 7'd0) begin
                    r.hours = t.hours - 7'd1;
                end else begin
                    r = cat_pkg::TIME_ZERO;
                end
            end
            cat_pkg::UNIT_MINUTES: begin
                if (t.hours == 7'd0 && t.minutes == 6'd0) begin
                    r = cat_pkg::TIME_ZERO;
                end else if (t.minutes != 6'd0) begin
                    r.minutes = t.minutes - 6'd1;
                end else begin
                    r.minutes = cat_pkg::MINUTES_MAX;
                    r.hours   = t.hours - 7'd1;
                end
            end
            cat_pkg::UNIT_SECONDS: begin
                r = dec_one(t);
            end
            default: begin
                r = t;
            end
        endcase
        return r;
    endfunction

    // Configuration registers.
    logic [7:0] period_reg;
    logic [7:0] slot_reg;

    // Timer state.
    cat_pkg::hms_t  remain_reg, remain_next;
    logic [7:0]     count_reg, count_next;
    cat_pkg::unit_t unit_reg, unit_next;
    logic           run_reg, run_next;
    logic           alarm_reg, alarm_next;

    // Result register.
    logic           m_valid_reg;
    cat_pkg::hms_t  out_remain_reg;
    logic           out_alarm_reg;
    logic           out_run_reg;
    cat_pkg::unit_t out_unit_reg;
    logic           out_refresh_reg;
    logic           out_msg_reg;

    logic           s_accept;
    logic [8:0]     count_inc;
    logic           remain_zero;
    cat_pkg::hms_t  after_up;
    cat_pkg::hms_t  after_down;
    cat_pkg::hms_t  tick_dec;
    cat_pkg::unit_t unit_mode;
    cat_pkg::unit_t unit_after_mode;
    logic           refresh_c;
    logic           msg_c;

    // The result register is free when empty or when its content leaves this cycle.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign remain_zero = (remain_reg == cat_pkg::TIME_ZERO);
    assign count_inc   = {1'b0, count_reg} + 9'd1;
    assign tick_dec    = dec_one(remain_reg);

    // Button chain: up acts in the old unit, down in the unit that mode leaves behind.
    assign after_up        = s_btn_up ? add_unit(remain_reg, unit_reg) : remain_reg;
    assign unit_mode       = (unit_reg >= cat_pkg::UNIT_SECONDS) ? cat_pkg::UNIT_HOURS
                                                                  : unit_reg + 2'd1;
    assign unit_after_mode = s_btn_mode ? unit_mode : unit_reg;
    assign after_down      = s_btn_down ? sub_unit(after_up, unit_after_mode) : after_up;

    always_comb begin
        remain_next = remain_reg;
        count_next  = count_reg;
        unit_next   = unit_reg;
        run_next    = run_reg;
        alarm_next  = alarm_reg;
        refresh_c   = 1'b0;
        msg_c       = 1'b0;
        if (s_accept) begin
            if (s_func == cat_pkg::FUNC_TICK) begin
                if (count_inc >= {1'b0, period_reg}) begin
                    count_next = 8'd0;
                end else begin
                    count_next = count_inc[7:0];
                    // A running countdown stuck at zero only counts ticks.
                    if (!(run_reg && remain_zero) && count_inc[7:0] == slot_reg) begin
                        refresh_c = 1'b1;
                        if (run_reg) begin
                            remain_next = tick_dec;
                            if (tick_dec == cat_pkg::TIME_ZERO) begin
                                alarm_next = 1'b1;
                                msg_c      = 1'b1;
                            end
                        end
                    end
                end
            end else begin
                remain_next = after_down;
                unit_next   = unit_after_mode;
                if (s_btn_start) begin
                    if (run_reg) begin
                        remain_next = cat_pkg::TIME_ZERO;
                        alarm_next  = 1'b0;
                        run_next    = 1'b0;
                    end else begin
                        run_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= cat_pkg::TICK_PERIOD_RESET;
            slot_reg   <= cat_pkg::REFRESH_SLOT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                cat_pkg::CFG_TICK_PERIOD:  period_reg <= cfg_data;
                cat_pkg::CFG_REFRESH_SLOT: slot_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg <= cat_pkg::TIME_ZERO;
            count_reg  <= 8'd0;
            unit_reg   <= cat_pkg::UNIT_HOURS;
            run_reg    <= 1'b0;
            alarm_reg  <= 1'b0;
        end else begin
            remain_reg <= remain_next;
            count_reg  <= count_next;
            unit_reg   <= unit_next;
            run_reg    <= run_next;
            alarm_reg  <= alarm_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_remain_reg  <= remain_next;
            out_alarm_reg   <= alarm_next;
            out_run_reg     <= run_next;
            out_unit_reg    <= unit_next;
            out_refresh_reg <= refresh_c;
            out_msg_reg     <= msg_c;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hours         = out_remain_reg.hours;
    assign m_minutes       = out_remain_reg.minutes;
    assign m_seconds       = out_remain_reg.seconds;
    assign m_alarm_out     = out_alarm_reg;
    assign m_running       = out_run_reg;
    assign m_edit_unit     = out_unit_reg;
    assign m_refresh       = out_refresh_reg;
    assign m_alarm_message = out_msg_reg;

    // The stored time never leaves 00:00:00 .. 99:59:59.
    assert property (@(posedge aclk) disable iff (!aresetn)
        remain_reg.hours <= cat_pkg::HOURS_MAX && remain_reg.minutes <= cat_pkg::MINUTES_MAX
        && remain_reg.seconds <= cat_pkg::SECONDS_MAX)
        else $error("stored time out of range");

    // The unused unit code is never entered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        unit_reg != cat_pkg::UNIT_UNUSED)
        else $error("edit unit holds unused code");

    // An alarm message only comes with a redraw, a raised alarm and zero time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_msg_reg |-> out_refresh_reg && out_alarm_reg && out_run_reg
        && out_remain_reg == cat_pkg::TIME_ZERO)
        else $error("alarm message without alarm at zero time");

    // A held result is not overwritten: nothing is taken while a stalled result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !s_accept)
        else $error("input taken over a stalled result");

    // Stopping with start clears the alarm along with the time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_func == cat_pkg::FUNC_BUTTON && s_btn_start && run_reg
        |=> !alarm_reg && !run_reg && remain_reg == cat_pkg::TIME_ZERO)
        else $error("stop did not clear time and alarm");

endmodule

`default_nettype wire
